[design/wkb_geometry_coordinate_scaler_core_assert.svh]
// Assertion macros shared by the scaler modules.
// Each macro expects clk_i and rst_ni in scope.
`ifndef WKB_GEOMETRY_COORDINATE_SCALER_CORE_ASSERT_SVH
`define WKB_GEOMETRY_COORDINATE_SCALER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define WKBCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define WKBCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/wkbcs_pkg.sv]
package wkbcs_pkg;

  // Parse phases of the geometry header and body
  typedef enum logic [3:0] {
    PH_SRID    = 4'd0,
    PH_ENDIAN  = 4'd1,
    PH_TYPE    = 4'd2,
    PH_NPOINTS = 4'd3,
    PH_NRINGS  = 4'd4,
    PH_RINGPTS = 4'd5,
    PH_PTHDR   = 4'd6,
    PH_COORD   = 4'd7,
    PH_DONE    = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_POINT = 2'd1,
    KIND_MULTI = 2'd2,
    KIND_POLY  = 2'd3
  } kind_e;

  // WKB geometry type codes
  localparam logic [31:0] WKB_POINT      = 32'd1;
  localparam logic [31:0] WKB_POLYGON    = 32'd3;
  localparam logic [31:0] WKB_MULTIPOINT = 32'd4;

  // Configuration register indexes
  localparam logic CFG_X_SCALE = 1'b0;
  localparam logic CFG_Y_SCALE = 1'b1;

  localparam logic [31:0] SCALE_RESET = 32'd1;

  // Queue depth, a power of two
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;

  // One queue entry: up to eight result bytes, optionally a coordinate to scale
  typedef struct packed {
    logic [63:0] data;
    logic [2:0]  cnt;    // number of result bytes minus one
    logic        last;
    logic        bad;
    logic        coord;
    logic        ysel;
  } entry_t;

  // Leading zero count of a 64-bit word (64 when zero)
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

endpackage

[design/wkb_geometry_coordinate_scaler_core.sv]
// WKB coordinate scaler.
// Input channel (in_valid_i/in_ready_o): one geometry byte per transaction,
// in_last_i on the final byte. Output channel (out_valid_o/out_ready_i): one
// result byte per transaction, out_last_o on the final one, bad_type_o on the
// single error transaction of an unsupported geometry type.
// Configuration: cfg_we_i writes cfg_data_i to x_scale (index 0) or y_scale
// (index 1); write only while no geometry is in flight.
// Every entry runs through the queue, the pipeline and the output serializer.
// A coordinate leaves as eight bytes, one per output transaction; scaling
// runs through a five-stage multiply/round pipeline.
// Throughput: one byte per cycle sustained while out_ready_i stays high, set by
// the output serializer that sends one byte per cycle.
// Reset: both scales go to 1 and the parser waits for an SRID byte.
// When the receiver stalls the pipeline holds, the queue (QDEPTH entries, four
// by default) fills and in_ready_o drops.
module wkb_geometry_coordinate_scaler_core
  import wkbcs_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        bad_type_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] x_scale_q, y_scale_q;
  logic        push, q_full, q_pop, q_valid;
  entry_t      push_ent, q_head;

  // Scale registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_scale_q <= SCALE_RESET;
      y_scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_X_SCALE: x_scale_q <= cfg_data_i;
        CFG_Y_SCALE: y_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wkbcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_ent_o (push_ent)
  );

  wkbcs_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  wkbcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .x_scale_i   (x_scale_q),
    .y_scale_i   (y_scale_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .bad_type_o  (bad_type_o)
  );

endmodule

[design/wkbcs_front.sv]
module wkbcs_front
  import wkbcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       push_o,
  output entry_t     push_ent_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  fbc_q, fbc_d;
  kind_e       kind_q, kind_d;
  logic [31:0] tg_q, tg_d;
  logic [31:0] rings_q, rings_d;
  logic [31:0] points_q, points_d;
  logic [63:0] coord_q, coord_d;
  logic        y_q, y_d;
  logic        disc_q, disc_d;

  logic        acc;
  logic        clear;
  logic [31:0] tg_ins, cnt_ins, cnt_san, pts_dec, rings_dec;
  logic [63:0] coord_ins;
  entry_t      byte_ent;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;

  // Byte lanes with the current byte dropped in
  always_comb begin
    tg_ins = tg_q;
    tg_ins[{fbc_q[1:0], 3'b000} +: 8] = in_byte_i;
    cnt_ins = (fbc_q == 3'd0) ? 32'd0 :
              ((phase_q == PH_NRINGS) ? rings_q : points_q);
    cnt_ins[{fbc_q[1:0], 3'b000} +: 8] = in_byte_i;
    coord_ins = coord_q;
    coord_ins[{fbc_q, 3'b000} +: 8] = in_byte_i;
  end

  assign cnt_san   = cnt_ins[31] ? 32'd0 : cnt_ins;
  assign pts_dec   = points_q - 32'd1;
  assign rings_dec = rings_q - 32'd1;

  always_comb begin
    byte_ent       = '0;
    byte_ent.data  = {56'd0, in_byte_i};
    byte_ent.last  = in_last_i;
  end

  // Parser next state and queue push
  always_comb begin
    phase_d    = phase_q;
    fbc_d      = fbc_q;
    kind_d     = kind_q;
    tg_d       = tg_q;
    rings_d    = rings_q;
    points_d   = points_q;
    coord_d    = coord_q;
    y_d        = y_q;
    disc_d     = disc_q;
    push_o     = 1'b0;
    push_ent_o = byte_ent;
    clear      = 1'b0;

    if (acc) begin
      if (disc_q) begin
        clear = in_last_i;
      end else begin
        clear = in_last_i;
        case (phase_q)
          PH_SRID: begin
            push_o = 1'b1;
            if (fbc_q == 3'd3) begin
              fbc_d   = 3'd0;
              phase_d = PH_ENDIAN;
            end else begin
              fbc_d = fbc_q + 3'd1;
            end
          end
          PH_ENDIAN: begin
            push_o  = 1'b1;
            phase_d = PH_TYPE;
          end
          PH_TYPE: begin
            push_o = 1'b1;
            tg_d   = tg_ins;
            if (fbc_q == 3'd3) begin
              fbc_d = 3'd0;
              case (tg_ins)
                WKB_POINT: begin
                  kind_d  = KIND_POINT;
                  y_d     = 1'b0;
                  phase_d = PH_COORD;
                end
                WKB_MULTIPOINT: begin
                  kind_d  = KIND_MULTI;
                  phase_d = PH_NPOINTS;
                end
                WKB_POLYGON: begin
                  kind_d  = KIND_POLY;
                  phase_d = PH_NRINGS;
                end
                default: begin
                  // unsupported type: one error transaction, drop the rest
                  push_ent_o      = '0;
                  push_ent_o.last = 1'b1;
                  push_ent_o.bad  = 1'b1;
                  clear           = 1'b1;
                end
              endcase
            end else begin
              fbc_d = fbc_q + 3'd1;
            end
          end
          PH_NPOINTS, PH_NRINGS, PH_RINGPTS: begin
            push_o = 1'b1;
            if (phase_q == PH_NRINGS) rings_d = cnt_ins;
            else                      points_d = cnt_ins;
            if (fbc_q == 3'd3) begin
              fbc_d = 3'd0;
              if (phase_q == PH_NRINGS) rings_d = cnt_san;
              else                      points_d = cnt_san;
              if (phase_q == PH_NPOINTS) begin
                phase_d = (cnt_san != '0) ? PH_PTHDR : PH_DONE;
              end else if (phase_q == PH_NRINGS) begin
                phase_d = (cnt_san != '0) ? PH_RINGPTS : PH_DONE;
              end else if (cnt_san != '0) begin
                y_d     = 1'b0;
                phase_d = PH_COORD;
              end else begin
                rings_d = rings_dec;
                phase_d = (rings_dec != '0) ? PH_RINGPTS : PH_DONE;
              end
            end else begin
              fbc_d = fbc_q + 3'd1;
            end
          end
          PH_PTHDR: begin
            push_o = 1'b1;
            if (fbc_q == 3'd4) begin
              fbc_d   = 3'd0;
              y_d     = 1'b0;
              phase_d = PH_COORD;
            end else begin
              fbc_d = fbc_q + 3'd1;
            end
          end
          PH_COORD: begin
            if (fbc_q == 3'd7) begin
              push_o           = 1'b1;
              push_ent_o.data  = coord_ins;
              push_ent_o.cnt   = 3'd7;
              push_ent_o.coord = 1'b1;
              push_ent_o.ysel  = y_q;
              coord_d          = '0;
              fbc_d            = 3'd0;
              if (!y_q) begin
                y_d = 1'b1;
              end else begin
                y_d = 1'b0;
                // point done
                case (kind_q)
                  KIND_POINT: phase_d = PH_DONE;
                  KIND_MULTI: begin
                    points_d = pts_dec;
                    phase_d  = (pts_dec != '0) ? PH_PTHDR : PH_DONE;
                  end
                  default: begin
                    points_d = pts_dec;
                    if (pts_dec != '0) begin
                      phase_d = PH_COORD;
                    end else begin
                      rings_d = rings_dec;
                      phase_d = (rings_dec != '0) ? PH_RINGPTS : PH_DONE;
                    end
                  end
                endcase
              end
            end else begin
              fbc_d   = fbc_q + 3'd1;
              coord_d = coord_ins;
              if (in_last_i) begin
                // unfinished coordinate goes out unscaled
                push_o          = 1'b1;
                push_ent_o.data = coord_ins;
                push_ent_o.cnt  = fbc_q;
              end
            end
          end
          default: begin
            push_o = 1'b1;
          end
        endcase
      end
    end

    if (clear) begin
      phase_d  = PH_SRID;
      fbc_d    = '0;
      kind_d   = KIND_NONE;
      tg_d     = '0;
      rings_d  = '0;
      points_d = '0;
      coord_d  = '0;
      y_d      = 1'b0;
      disc_d   = acc && !disc_q && !in_last_i && push_ent_o.bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SRID;
      fbc_q    <= '0;
      kind_q   <= KIND_NONE;
      tg_q     <= '0;
      rings_q  <= '0;
      points_q <= '0;
      coord_q  <= '0;
      y_q      <= 1'b0;
      disc_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fbc_q    <= fbc_d;
      kind_q   <= kind_d;
      tg_q     <= tg_d;
      rings_q  <= rings_d;
      points_q <= points_d;
      coord_q  <= coord_d;
      y_q      <= y_d;
      disc_q   <= disc_d;
    end
  end

endmodule

[design/wkbcs_fifo.sv]
module wkbcs_fifo
  import wkbcs_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_ent_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_ent_i;
  end

  // Pointers wrap naturally for a power-of-two depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= AW'(wr_q + 1'b1);
      if (pop_i)  rd_q <= AW'(rd_q + 1'b1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

`include "wkb_geometry_coordinate_scaler_core_assert.svh"

  `WKBCS_ASSERT_NOW(a_no_overflow, push_i, !full_o, "queue push while full")
  `WKBCS_ASSERT_NOW(a_no_underflow, pop_i, valid_o, "queue pop while empty")
  `WKBCS_ASSERT_NEXT(a_fill_up, push_i && !pop_i, cnt_q == CW'($past(cnt_q) + 1'b1), "count slip")

endmodule

[design/wkbcs_back.sv]
module wkbcs_back
  import wkbcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] x_scale_i,
  input  logic [31:0] y_scale_i,
  input  logic        q_valid_i,
  input  entry_t      q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        bad_type_o
);

  typedef struct packed {
    logic [63:0] val;   // final value when spec is set
    logic        spec;
    logic        sgn;
    logic [2:0]  cnt;
    logic        last;
    logic        bad;
  } meta_t;

  // stage valids and metadata
  logic  v1_q, v2_q, v3_q, v4_q, v5_q;
  meta_t m1_q, m2_q, m3_q, m4_q, m5_q, m1_d;
  logic  adv;

  // serializer
  logic        ser_busy_q;
  logic [63:0] ser_data_q;
  logic [2:0]  ser_cnt_q, ser_idx_q;
  logic        ser_last_q, ser_bad_q;
  logic        ser_fin;

  assign out_valid_o = ser_busy_q;
  assign out_byte_o  = ser_data_q[{ser_idx_q, 3'b000} +: 8];
  assign out_last_o  = ser_last_q && (ser_idx_q == ser_cnt_q);
  assign bad_type_o  = ser_bad_q;
  assign ser_fin     = ser_busy_q && out_ready_i && (ser_idx_q == ser_cnt_q);
  assign adv         = !ser_busy_q || ser_fin;
  assign q_pop_o     = adv && q_valid_i;

  // Stage 1: operand unpack, special values, leading zero counts
  logic [31:0] sc, abs_s;
  logic [10:0] ex, e1_d;
  logic [51:0] man;
  logic [52:0] m53_d;
  logic [5:0]  lzm_d;
  logic [4:0]  lzs_d;
  logic [10:0] e1_q;
  logic [52:0] m1m_q;
  logic [31:0] s1_q;
  logic [5:0]  lzm1_q;
  logic [4:0]  lzs1_q;

  always_comb begin
    sc    = q_head_i.ysel ? y_scale_i : x_scale_i;
    abs_s = sc[31] ? 32'(-sc) : sc;
    ex    = q_head_i.data[62:52];
    man   = q_head_i.data[51:0];
    m53_d = (ex == 11'd0) ? {1'b0, man} : {1'b1, man};
    e1_d  = (ex == 11'd0) ? 11'd1 : ex;
    lzm_d = 6'(lzc64({m53_d, 11'd0}));
    lzs_d = 5'(lzc64({abs_s, 32'd0}));

    m1_d      = '0;
    m1_d.cnt  = q_head_i.cnt;
    m1_d.last = q_head_i.last;
    m1_d.bad  = q_head_i.bad;
    m1_d.sgn  = q_head_i.data[63] ^ sc[31];
    m1_d.spec = 1'b1;
    if (!q_head_i.coord) begin
      m1_d.val = q_head_i.data;
    end else if (ex == 11'h7FF && man != '0) begin
      // NaN keeps its payload, quiet bit forced
      m1_d.val = q_head_i.data | 64'h0008_0000_0000_0000;
    end else if (ex == 11'h7FF) begin
      m1_d.val = (sc == '0) ? DEFAULT_NAN : {m1_d.sgn, 11'h7FF, 52'd0};
    end else if ((ex == 11'd0 && man == '0) || sc == '0) begin
      m1_d.val = {m1_d.sgn, 63'd0};
    end else begin
      m1_d.spec = 1'b0;
    end
  end

  // Stage 2: normalise both operands
  logic [52:0] mn2_q;
  logic [31:0] sn2_q;
  logic [10:0] e2_q;
  logic [5:0]  lzm2_q;
  logic [4:0]  lzs2_q;

  // Stage 3: partial products
  logic [63:0] pplo3_q;
  logic [52:0] pphi3_q;
  logic [10:0] e3_q;
  logic [5:0]  lzm3_q;
  logic [4:0]  lzs3_q;

  // Stage 4: product sum, one-bit normalise, biased exponent
  logic [84:0]        prod, fnorm_d;
  logic signed [12:0] exp_d;
  logic [84:0]        f4_q;
  logic signed [12:0] exp4_q;

  assign prod    = {pphi3_q, 32'd0} + {21'd0, pplo3_q};
  assign fnorm_d = prod[84] ? prod : {prod[83:0], 1'b0};
  assign exp_d   = $signed({2'b00, e3_q}) + 13'sd31 + $signed({12'd0, prod[84]})
                 - $signed({7'd0, lzm3_q}) - $signed({8'd0, lzs3_q});

  // Stage 5: denormal shift with sticky
  logic [148:0] wide;
  logic [5:0]   dsh;
  logic [84:0]  kept;
  logic         lost;
  logic [11:0]  eb_d;
  logic [52:0]  mant5_q;
  logic         g5_q, st5_q, ovf5_q;
  logic [11:0]  eb5_q;

  always_comb begin
    dsh  = 6'(13'sd1 - exp4_q);
    wide = {f4_q, 64'd0} >> dsh;
    if (exp4_q <= 13'sd0) begin
      kept = wide[148:64];
      lost = |wide[63:0];
      eb_d = 12'd0;
    end else begin
      kept = f4_q;
      lost = 1'b0;
      eb_d = 12'(exp4_q - 13'sd1);
    end
  end

  // Rounding to nearest even and packing
  logic        rnd;
  logic [63:0] packed_sum, result;

  always_comb begin
    rnd        = g5_q && (st5_q || mant5_q[0]);
    packed_sum = {eb5_q, 52'd0} + {11'd0, mant5_q} + {63'd0, rnd};
    if (m5_q.spec) begin
      result = m5_q.val;
    end else if (ovf5_q || packed_sum[63:52] >= 12'd2047) begin
      result = {m5_q.sgn, 11'h7FF, 52'd0};
    end else begin
      result = {m5_q.sgn, packed_sum[62:0]};
    end
  end

  // Pipeline payload, moves as one on adv
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q    <= m1_d;
      e1_q    <= e1_d;
      m1m_q   <= m53_d;
      s1_q    <= abs_s;
      lzm1_q  <= lzm_d;
      lzs1_q  <= lzs_d;

      m2_q    <= m1_q;
      mn2_q   <= m1m_q << lzm1_q;
      sn2_q   <= s1_q << lzs1_q;
      e2_q    <= e1_q;
      lzm2_q  <= lzm1_q;
      lzs2_q  <= lzs1_q;

      m3_q    <= m2_q;
      pplo3_q <= {32'd0, mn2_q[31:0]} * {32'd0, sn2_q};
      pphi3_q <= {32'd0, mn2_q[52:32]} * {21'd0, sn2_q};
      e3_q    <= e2_q;
      lzm3_q  <= lzm2_q;
      lzs3_q  <= lzs2_q;

      m4_q    <= m3_q;
      f4_q    <= fnorm_d;
      exp4_q  <= exp_d;

      m5_q    <= m4_q;
      mant5_q <= kept[84:32];
      g5_q    <= kept[31];
      st5_q   <= (|kept[30:0]) || lost;
      eb5_q   <= eb_d;
      ovf5_q  <= (exp4_q >= 13'sd2047);
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Output serializer: one byte per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_busy_q <= 1'b0;
      ser_idx_q  <= '0;
    end else if (adv) begin
      ser_busy_q <= v5_q;
      ser_idx_q  <= '0;
    end else if (out_ready_i) begin
      ser_idx_q <= ser_idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ser_data_q <= result;
      ser_cnt_q  <= m5_q.cnt;
      ser_last_q <= m5_q.last;
      ser_bad_q  <= m5_q.bad;
    end
  end

`include "wkb_geometry_coordinate_scaler_core_assert.svh"

  `WKBCS_ASSERT_NOW(a_idx_range, ser_busy_q, ser_idx_q <= ser_cnt_q, "serializer index past end")
  `WKBCS_ASSERT_NOW(a_bad_single, ser_busy_q && ser_bad_q,
                    ser_last_q && ser_cnt_q == 3'd0, "error transaction malformed")
  `WKBCS_ASSERT_NEXT(a_stall_hold, v5_q && !adv, v5_q, "pipeline lost an entry")

endmodule

[bench/tb_wkb_geometry_coordinate_scaler_core.sv]
module tb_wkb_geometry_coordinate_scaler_core;
  import wkbcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } res_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid_o;
  logic        out_ready;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic        bad_type_o;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // Output handshake control
  logic        rx_hold;
  logic        no_idle;

  int unsigned errors;
  int unsigned cycles;

  // Result bytes still owed by the block, oldest first
  res_t        owed_bytes[$];
  logic [7:0]  geo_bytes[$];
  dir_row_t    dir_tab[$];

  // Model of the parser and the two scales
  logic [31:0] scale_x, scale_y;
  phase_e      phase;
  kind_e       kind;
  int          fcnt;
  logic [31:0] type_acc;
  logic [31:0] rings_left, points_left;
  logic [63:0] coord_acc;
  logic        on_y;
  logic        dropping;

  wkb_geometry_coordinate_scaler_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte),
    .in_last_i  (in_last),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .bad_type_o (bad_type_o),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_wkb_geometry_coordinate_scaler_core: FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure, always ready under no_idle, or a hard hold when asked
  always @(posedge clk_i) begin
    if (rx_hold) begin
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 20);
    end
  end

  // Result checker; sampled mid-cycle so every signal is settled
  always @(negedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (owed_bytes.size() == 0) begin
        $display("%0t: unexpected transaction byte %h last %b bad %b", $realtime,
                 out_byte_o, out_last_o, bad_type_o);
        errors++;
      end else begin
        want = owed_bytes.pop_front();
        if (out_byte_o !== want.data) begin
          $display("%0t: byte expected %h actual %h", $realtime, want.data, out_byte_o);
          errors++;
        end
        if (out_last_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $realtime, want.last, out_last_o);
          errors++;
        end
        if (bad_type_o !== want.bad) begin
          $display("%0t: bad_type expected %b actual %b", $realtime, want.bad, bad_type_o);
          errors++;
        end
      end
    end
  end

  task automatic clear_parse();
    phase = PH_SRID;
    kind = KIND_NONE;
    fcnt = 0;
    type_acc = '0;
    rings_left = '0;
    points_left = '0;
    coord_acc = '0;
    on_y = 1'b0;
    dropping = 1'b0;
  endtask

  // Coordinate times integer scale, with the NaN and infinity-by-zero rules
  function automatic logic [63:0] scaled(logic [63:0] bits, logic [31:0] sc);
    real d;
    if (bits[62:52] == 11'h7FF && bits[51:0] != '0) return bits | (64'd1 << 51);
    if (bits[62:52] == 11'h7FF && sc == '0) return DEFAULT_NAN;
    d = $bitstoreal(bits);
    return $realtobits(d * $itor($signed(sc)));
  endfunction

  task automatic ring_done();
    rings_left--;
    phase = (rings_left != 0) ? PH_RINGPTS : PH_DONE;
  endtask

  task automatic point_done();
    if (kind == KIND_POINT) begin
      phase = PH_DONE;
    end else if (kind == KIND_MULTI) begin
      points_left--;
      phase = (points_left != 0) ? PH_PTHDR : PH_DONE;
    end else begin
      points_left--;
      if (points_left != 0) phase = PH_COORD;
      else ring_done();
    end
  endtask

  // Work out the bytes that one input transaction causes
  task automatic predict(input logic [7:0] b, input logic l);
    int unsigned n0;
    logic [63:0] r;
    n0 = owed_bytes.size();
    if (dropping) begin
      if (l) clear_parse();
      return;
    end
    case (phase)
      PH_SRID: begin
        owed_bytes.push_back('{b, 1'b0, 1'b0});
        fcnt++;
        if (fcnt >= 4) begin
          fcnt = 0;
          phase = PH_ENDIAN;
        end
      end
      PH_ENDIAN: begin
        owed_bytes.push_back('{b, 1'b0, 1'b0});
        phase = PH_TYPE;
      end
      PH_TYPE: begin
        type_acc |= 32'(b) << (8 * (fcnt % 4));
        fcnt++;
        if (fcnt >= 4) begin
          fcnt = 0;
          if (type_acc == WKB_POINT) begin
            kind = KIND_POINT;
            on_y = 1'b0;
            phase = PH_COORD;
          end else if (type_acc == WKB_MULTIPOINT) begin
            kind = KIND_MULTI;
            phase = PH_NPOINTS;
          end else if (type_acc == WKB_POLYGON) begin
            kind = KIND_POLY;
            phase = PH_NRINGS;
          end else begin
            // unsupported type: one error transaction, then drop to in_last
            owed_bytes.push_back('{8'h00, 1'b1, 1'b1});
            clear_parse();
            if (!l) dropping = 1'b1;
            return;
          end
        end
        owed_bytes.push_back('{b, 1'b0, 1'b0});
      end
      PH_NPOINTS, PH_NRINGS, PH_RINGPTS: begin
        owed_bytes.push_back('{b, 1'b0, 1'b0});
        if (phase == PH_NRINGS) begin
          if (fcnt == 0) rings_left = '0;
          rings_left |= 32'(b) << (8 * (fcnt % 4));
        end else begin
          if (fcnt == 0) points_left = '0;
          points_left |= 32'(b) << (8 * (fcnt % 4));
        end
        fcnt++;
        if (fcnt >= 4) begin
          fcnt = 0;
          // negative counts read as zero
          if (rings_left[31]) rings_left = '0;
          if (points_left[31]) points_left = '0;
          if (phase == PH_NPOINTS) begin
            phase = (points_left != 0) ? PH_PTHDR : PH_DONE;
          end else if (phase == PH_NRINGS) begin
            phase = (rings_left != 0) ? PH_RINGPTS : PH_DONE;
          end else if (points_left != 0) begin
            on_y = 1'b0;
            phase = PH_COORD;
          end else begin
            ring_done();
          end
        end
      end
      PH_PTHDR: begin
        owed_bytes.push_back('{b, 1'b0, 1'b0});
        fcnt++;
        if (fcnt >= 5) begin
          fcnt = 0;
          on_y = 1'b0;
          phase = PH_COORD;
        end
      end
      PH_COORD: begin
        coord_acc |= 64'(b) << (8 * (fcnt % 8));
        fcnt++;
        if (fcnt >= 8) begin
          r = scaled(coord_acc, on_y ? scale_y : scale_x);
          for (int i = 0; i < 8; i++) owed_bytes.push_back('{r[8*i +: 8], 1'b0, 1'b0});
          fcnt = 0;
          coord_acc = '0;
          if (on_y) begin
            on_y = 1'b0;
            point_done();
          end else begin
            on_y = 1'b1;
          end
        end else if (l) begin
          // unfinished coordinate goes out as gathered
          for (int i = 0; i < fcnt; i++) owed_bytes.push_back('{coord_acc[8*i +: 8], 1'b0, 1'b0});
        end
      end
      default: owed_bytes.push_back('{b, 1'b0, 1'b0});
    endcase
    if (l) begin
      if (owed_bytes.size() > n0) owed_bytes[$].last = 1'b1;
      clear_parse();
    end
  endtask

  // Offer one byte and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b, input logic l);
    logic ok;
    if (!no_idle && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do begin
      @(negedge clk_i);
      ok = in_ready_o;
      @(posedge clk_i);
    end while (!ok);
  endtask

  task automatic wait_drained();
    while (owed_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scales(input logic [31:0] xs, input logic [31:0] ys);
    @(posedge clk_i);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= CFG_X_SCALE;
    cfg_data <= xs;
    @(posedge clk_i);
    cfg_index <= CFG_Y_SCALE;
    cfg_data <= ys;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    scale_x = xs;
    scale_y = ys;
  endtask

  function automatic void put_u32(logic [31:0] v);
    for (int i = 0; i < 4; i++) geo_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_coord();
    logic [63:0] c;
    logic        s;
    s = $urandom_range(1);
    case ($urandom_range(9))
      0: c = {$urandom, $urandom};
      1: c = {s, 11'h7FF, 52'h0};
      2: c = {s, 11'h7FF, 20'($urandom), 31'($urandom), 1'b1};
      3: c = {s, 63'h0};
      4: c = {s, 11'h000, 20'($urandom), 32'($urandom)};
      5: c = {s, 11'h7FE, 20'($urandom), 32'($urandom)};
      default: c = $realtobits($itor($urandom_range(4000)) / 8.0 - 250.0);
    endcase
    for (int i = 0; i < 8; i++) geo_bytes.push_back(c[8*i +: 8]);
  endfunction

  // Count field: mostly small, now and then negative
  function automatic logic [31:0] pick_count(int unsigned hi);
    if ($urandom_range(9) == 0) return 32'h8000_0000 | 32'($urandom);
    return 32'($urandom_range(hi));
  endfunction

  // Build one geometry into geo_bytes, well formed most of the time
  function automatic void build_geometry();
    logic [31:0] t, nr, np;
    int unsigned sel;
    geo_bytes.delete();
    put_u32($urandom);
    geo_bytes.push_back(8'($urandom));
    sel = $urandom_range(99);
    if (sel < 25) begin
      put_u32(WKB_POINT);
      put_coord();
      put_coord();
    end else if (sel < 50) begin
      put_u32(WKB_MULTIPOINT);
      np = pick_count(2);
      put_u32(np);
      if (!np[31]) begin
        for (int p = 0; p < np; p++) begin
          for (int h = 0; h < 5; h++) geo_bytes.push_back(8'($urandom));
          put_coord();
          put_coord();
        end
      end
    end else if (sel < 80) begin
      put_u32(WKB_POLYGON);
      nr = pick_count(2);
      put_u32(nr);
      if (!nr[31]) begin
        for (int r = 0; r < nr; r++) begin
          np = pick_count(2);
          put_u32(np);
          if (!np[31]) begin
            for (int p = 0; p < np; p++) begin
              put_coord();
              put_coord();
            end
          end
        end
      end
    end else begin
      t = $urandom_range(1) ? 32'($urandom_range(15)) : $urandom;
      if (t == WKB_POINT || t == WKB_POLYGON || t == WKB_MULTIPOINT) t = 32'd2;
      put_u32(t);
      repeat ($urandom_range(6)) geo_bytes.push_back(8'($urandom));
    end
    // trailing noise or an early end
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 4)) geo_bytes.push_back(8'($urandom));
    if ($urandom_range(9) == 0) begin
      sel = $urandom_range(1, geo_bytes.size());
      while (geo_bytes.size() > sel) void'(geo_bytes.pop_back());
    end
  endfunction

  initial begin
    logic [31:0] xs[6];
    logic [31:0] ys[6];
    int unsigned sz, phase_bytes;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    in_last = 1'b0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_X_SCALE;
    cfg_data = '0;
    rx_hold = 1'b0;
    no_idle = 1'b0;
    errors = 0;
    cycles = 0;
    scale_x = SCALE_RESET;
    scale_y = SCALE_RESET;
    clear_parse();

    // Directed: unsupported type ending on its type, then a point with NaN x
    // and a y cut short by in_last
    dir_tab.push_back('{8'h11, 1'b0, 1'b1, '{8'h11, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h22, 1'b0, 1'b1, '{8'h22, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h33, 1'b0, 1'b1, '{8'h33, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h44, 1'b0, 1'b1, '{8'h44, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h01, 1'b0, 1'b1, '{8'h01, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h02, 1'b0, 1'b1, '{8'h02, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}});
    for (int i = 0; i < 4; i++) dir_tab.push_back('{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h01, 1'b0, 1'b1, '{8'h01, 1'b0, 1'b0}});
    for (int i = 0; i < 3; i++) dir_tab.push_back('{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h01, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}});
    for (int i = 0; i < 5; i++) dir_tab.push_back('{8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}});
    dir_tab.push_back('{8'hF0, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h7F, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}});
    dir_tab.push_back('{8'hA5, 1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}});
    dir_tab.push_back('{8'h5A, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}});

    // Scale settings per random phase, extremes included
    xs = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, $urandom, 32'd2};
    ys = '{32'd1, 32'd3, 32'd0, 32'h8000_0000, $urandom, 32'hFFFF_FFFE};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].l);
      sz = owed_bytes.size();
      predict(dir_tab[i].b, dir_tab[i].l);
      if (dir_tab[i].typed) begin
        while (owed_bytes.size() > sz) void'(owed_bytes.pop_back());
        owed_bytes.push_back(dir_tab[i].want);
      end
    end
    in_valid <= 1'b0;
    wait_drained();

    // Random phases, one scale setting each
    for (int p = 0; p < 6; p++) begin
      write_scales(xs[p], ys[p]);
      no_idle <= (p == 1);
      if (p == 3) begin
        // long receiver hold while the sender keeps offering
        fork
          begin
            rx_hold <= 1'b1;
            repeat (300) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end
      phase_bytes = 0;
      while (phase_bytes < 45) begin
        build_geometry();
        foreach (geo_bytes[k]) begin
          send_byte(geo_bytes[k], k == geo_bytes.size() - 1);
          predict(geo_bytes[k], k == geo_bytes.size() - 1);
        end
        phase_bytes += geo_bytes.size();
      end
      in_valid <= 1'b0;
      wait_drained();
      no_idle <= 1'b0;
    end

    if (errors == 0) begin
      $display("tb_wkb_geometry_coordinate_scaler_core: PASS");
    end else begin
      $display("tb_wkb_geometry_coordinate_scaler_core: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/wkbcs_pkg.sv
design/wkbcs_front.sv
design/wkbcs_fifo.sv
design/wkbcs_back.sv
design/wkb_geometry_coordinate_scaler_core.sv
bench/tb_wkb_geometry_coordinate_scaler_core.sv
